/* design/lttf_pkg.sv */
// ----------------------------------------------------------------------------
// lttf_pkg
// Shared types and constants for the log transmit FIFO with hex formatter:
// request and result structs, command codes, and the hex digit encoder.
// ----------------------------------------------------------------------------
package lttf_pkg;

  // Command codes carried in the request
  localparam logic [1:0] CMD_PUT_CHAR = 2'd0;
  localparam logic [1:0] CMD_PUT_HEX  = 2'd1;
  localparam logic [1:0] CMD_TX_TICK  = 2'd2;

  // Largest digit count that a put-hex request honors
  localparam int unsigned MAX_DIGITS = 8;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] data;
    logic [3:0]  digit_count;
  } in_req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       byte_valid;
    logic [3:0] accepted_count;
    logic       buffer_empty;
    logic       buffer_full;
    logic       send_done;
  } out_rsp_t;

  // Control from the buffer sequencer to the hex digit generator
  typedef struct packed {
    logic start;
    logic step;
  } hex_ctl_t;

  // Encode one nibble as uppercase ASCII
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'd0, nib};
    end else begin
      res = 8'h41 + {4'd0, nib} - 8'd10;
    end
    return res;
  endfunction

endpackage

/* design/lttf_hex_gen.sv */
// ----------------------------------------------------------------------------
// lttf_hex_gen
// Holds a value and a remaining digit count and presents the next hex
// character, most significant digit first, one digit per step.
// ----------------------------------------------------------------------------
module lttf_hex_gen (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lttf_pkg::hex_ctl_t ctl_i,
  input  logic [31:0]       value_i,
  input  logic [3:0]        count_i,
  output logic              more_o,
  output logic [7:0]        char_o
);

  logic [31:0] value_q;
  logic [3:0]  left_q, left_d;
  logic [3:0]  idx;
  logic [3:0]  nib;

  // Load on start, count down on each step
  always_comb begin
    left_d = left_q;
    if (ctl_i.start) begin
      left_d = count_i;
    end else if (ctl_i.step && (left_q != 4'd0)) begin
      left_d = left_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else begin
      left_q <= left_d;
    end
  end

  // Hold the value for the whole request
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      value_q <= value_i;
    end
  end

  // Select the current digit; digits above bit 31 read as zero
  always_comb begin
    idx = left_q - 4'd1;
    nib = idx[3] ? 4'd0 : value_q[{idx[2:0], 2'b00} +: 4];
  end

  assign more_o = (left_q != 4'd0);
  assign char_o = lttf_pkg::hex_char(nib);

endmodule

/* design/log_transmit_fifo_with_hex_format.sv */
// A request is taken only in the idle state: in_stall_o stays high until
// its result is in the result register, which waits while the far side
// stalls the previous one. Put-hex digits use the single write port of the
// byte memory, one character written per cycle while the buffer has room.
// Reset clears both ring pointers and the send-done flag; the byte memory is
// not cleared and needs no sweep, so requests are taken right after reset.
// ----------------------------------------------------------------------------
// log_transmit_fifo_with_hex_format
// Byte ring buffer feeding a serial transmitter. Appends single characters
// or formatted hex digits, pops one byte per transmit tick, and keeps a
// sticky send-done flag for ticks that find the buffer empty.
// ----------------------------------------------------------------------------
module log_transmit_fifo_with_hex_format #(
  parameter int unsigned DEPTH = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lttf_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lttf_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LastPos = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEX,
    ST_FIN
  } state_e;

  state_e             state_q;
  logic [AW-1:0]      wr_q, rd_q;
  logic [AW-1:0]      wr_adv, rd_adv;
  logic               done_q;
  logic [3:0]         acc_q;
  logic               txv_q;
  logic               out_valid_q;
  lttf_pkg::out_rsp_t out_rsp_q;

  logic [7:0]         mem [DEPTH];
  logic [7:0]         rdata_q;

  logic               in_acc;
  logic               full_w, empty_w;
  logic               we, re;
  logic [7:0]         wdata;
  logic [3:0]         digit_n;
  logic               slot_free;

  lttf_pkg::hex_ctl_t hex_ctl;
  logic               hex_more;
  logic [7:0]         hex_char;

  // Ring position arithmetic
  assign wr_adv  = (wr_q == LastPos) ? '0 : wr_q + 1'b1;
  assign rd_adv  = (rd_q == LastPos) ? '0 : rd_q + 1'b1;
  assign full_w  = (wr_adv == rd_q);
  assign empty_w = (wr_q == rd_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;

  // Clamp the requested digit count
  assign digit_n = ({1'b0, in_req_i.digit_count} > 5'(lttf_pkg::MAX_DIGITS))
                 ? 4'(lttf_pkg::MAX_DIGITS) : in_req_i.digit_count;

  // Drive the memory ports and the digit generator
  always_comb begin
    we            = 1'b0;
    re            = 1'b0;
    wdata         = in_req_i.data[7:0];
    hex_ctl.start = 1'b0;
    hex_ctl.step  = 1'b0;
    if (in_acc) begin
      case (in_req_i.command)
        lttf_pkg::CMD_PUT_CHAR: we = !full_w;
        lttf_pkg::CMD_PUT_HEX:  hex_ctl.start = 1'b1;
        lttf_pkg::CMD_TX_TICK:  re = !empty_w;
        default: ;
      endcase
    end else if (state_q == ST_HEX && hex_more && !full_w) begin
      we           = 1'b1;
      wdata        = hex_char;
      hex_ctl.step = 1'b1;
    end
  end

  lttf_hex_gen u_hex_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (hex_ctl),
    .value_i (in_req_i.data),
    .count_i (digit_n),
    .more_o  (hex_more),
    .char_o  (hex_char)
  );

  // Byte memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_q] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[rd_q];
    end
  end

  // Sequence requests, advance pointers, hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_q        <= '0;
      rd_q        <= '0;
      done_q      <= 1'b0;
      acc_q       <= '0;
      txv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      // drop the result once the far side takes it
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      if (we) begin
        wr_q <= wr_adv;
      end
      if (re) begin
        rd_q <= rd_adv;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            acc_q   <= {3'd0, we};
            txv_q   <= re;
            state_q <= (in_req_i.command == lttf_pkg::CMD_PUT_HEX) ? ST_HEX : ST_FIN;
            if (in_req_i.command == lttf_pkg::CMD_TX_TICK && empty_w) begin
              done_q <= 1'b1;
            end
          end
        end
        ST_HEX: begin
          if (we) begin
            acc_q <= acc_q + 4'd1;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_valid_q              <= 1'b1;
            out_rsp_q.tx_byte        <= txv_q ? rdata_q : 8'd0;
            out_rsp_q.byte_valid     <= txv_q;
            out_rsp_q.accepted_count <= acc_q;
            out_rsp_q.buffer_empty   <= empty_w;
            out_rsp_q.buffer_full    <= full_w;
            out_rsp_q.send_done      <= done_q;
            state_q                  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
